/* hdl/art_pkg.sv */
package art_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // one table slot as stored in the RAM word
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [47:0] mac;
    logic [7:0]  port;
    logic [7:0]  hops;
    logic [31:0] born;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hdl/art_ram.sv */
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/aging_route_table_unit.sv */
// Route table with aging, keyed by destination IPv4 address.
// Request channel (in_valid / in_stall) carries req_type and the route fields;
// one result per request leaves on the result channel (out_valid / out_stall).
// timeout_seconds is written through cfg_write / cfg_wdata; the user must write
// it only while no request is in flight, the block does not enforce this.
// All slots live in one RAM with a registered read. Add, delete and lookup
// sweep every slot: one read per cycle, purge of expired slots (add and lookup
// only) and key match on the returned word, write-back of removed slots in the
// cycle after the read. Add writes the new route in a closing cycle. A request
// passes the SCAN, FLUSH, FINISH and PUT states to the result register, a tick
// goes straight to PUT; a new request is taken in the cycle after the result is
// registered, so requests do not overlap; the rate is set by the single RAM
// read port. Reset clears the seconds counter and timeout and then runs a
// clearing sweep over all ENTRIES slots of the RAM; requests stall until it is
// done. A stalled result stays in the output register; the next request is
// still accepted and computed, and waits for the register only at its end.
module aging_route_table_unit #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] dest_ip,
  input  logic [47:0] dest_mac,
  input  logic [7:0]  out_port,
  input  logic [7:0]  new_hops,
  input  logic        force_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        found,
  output logic [7:0]  route_port,
  output logic [7:0]  route_hops,
  output logic [47:0] route_mac
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_FLUSH  = 6'b001000,
    S_FINISH = 6'b010000,
    S_PUT    = 6'b100000
  } state_t;

  state_t state;

  logic [15:0] timeout_seconds;
  logic [31:0] now_seconds;

  // latched request
  art_pkg::req_t req_op;
  logic [31:0]   req_ip;
  logic [47:0]   req_mac;
  logic [7:0]    req_port;
  logic [7:0]    req_hops;
  logic          req_force;

  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] chk_idx;
  logic             chk;

  // sweep results
  logic             match_hit;
  logic             reject_hit;
  logic [47:0]      match_mac;
  logic [7:0]       match_port;
  logic [7:0]       match_hops;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;

  // pending result
  art_pkg::status_t res_status;
  logic             res_found;
  logic [7:0]       res_port;
  logic [7:0]       res_hops;
  logic [47:0]      res_mac;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [art_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [art_pkg::ENTRY_W-1:0]  ram_rdata;

  art_pkg::entry_t rd_word;
  art_pkg::entry_t kill_word;
  art_pkg::entry_t new_word;
  logic [31:0]     age;
  logic            do_purge;
  logic            kill;
  logic            live;
  logic            is_match;
  logic            worse;
  logic            remove;
  logic            slot_free;
  logic            out_free;

  art_ram #(
    .WIDTH(art_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    rd_word  = art_pkg::entry_t'(ram_rdata);
    age      = now_seconds - rd_word.born;
    do_purge = (req_op == art_pkg::REQ_ADD) || (req_op == art_pkg::REQ_LOOKUP);
    kill     = chk && rd_word.valid && do_purge && (age >= {16'd0, timeout_seconds});
    live     = rd_word.valid && !kill;
    is_match = chk && live && (rd_word.key == req_ip);
    worse    = !req_force && (rd_word.hops != 8'd0) && (rd_word.hops < req_hops);
    remove   = is_match && ((req_op == art_pkg::REQ_DELETE) ||
                            ((req_op == art_pkg::REQ_ADD) && !worse));
    // removal of the old route comes before the free-slot search
    slot_free = chk && (!live || remove);

    kill_word       = rd_word;
    kill_word.valid = 1'b0;

    new_word.valid = 1'b1;
    new_word.key   = req_ip;
    new_word.mac   = req_mac;
    new_word.port  = req_port;
    new_word.hops  = req_hops;
    new_word.born  = now_seconds;

    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = kill_word;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (chk) begin
      ram_we = kill || remove;
    end else if (state == S_FINISH) begin
      ram_we    = (req_op == art_pkg::REQ_ADD) && !reject_hit && free_hit;
      ram_waddr = free_idx;
      ram_wdata = new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_idx         <= '0;
      rd_idx          <= '0;
      chk             <= 1'b0;
      timeout_seconds <= 16'd0;
      now_seconds     <= 32'd0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        timeout_seconds <= cfg_wdata;
      end

      chk     <= (state == S_SCAN);
      chk_idx <= rd_idx;

      if ((state == S_PUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (chk) begin
        if (is_match) begin
          match_hit  <= 1'b1;
          reject_hit <= (req_op == art_pkg::REQ_ADD) && worse;
          match_mac  <= rd_word.mac;
          match_port <= rd_word.port;
          match_hops <= rd_word.hops;
        end
        if (slot_free && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= chk_idx;
        end
      end

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_op     <= art_pkg::req_t'(req_type);
            req_ip     <= dest_ip;
            req_mac    <= dest_mac;
            req_port   <= out_port;
            req_hops   <= new_hops;
            req_force  <= force_req;
            rd_idx     <= '0;
            match_hit  <= 1'b0;
            reject_hit <= 1'b0;
            free_hit   <= 1'b0;
            res_status <= art_pkg::ST_OK;
            res_found  <= 1'b0;
            res_port   <= 8'd0;
            res_hops   <= 8'd0;
            res_mac    <= 48'd0;
            if (art_pkg::req_t'(req_type) == art_pkg::REQ_TICK) begin
              now_seconds <= now_seconds + 32'd1;
              state       <= S_PUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_idx == LAST_IDX) begin
            state <= S_FLUSH;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_FLUSH: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          case (req_op)
            art_pkg::REQ_ADD: begin
              if (reject_hit) begin
                res_status <= art_pkg::ST_REJECTED;
              end else if (!free_hit) begin
                res_status <= art_pkg::ST_FULL;
              end
            end
            art_pkg::REQ_DELETE: begin
              if (!match_hit) begin
                res_status <= art_pkg::ST_NOT_FOUND;
              end
            end
            art_pkg::REQ_LOOKUP: begin
              if (match_hit) begin
                res_found <= 1'b1;
                res_port  <= match_port;
                res_hops  <= match_hops;
                res_mac   <= match_mac;
              end else begin
                res_status <= art_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              res_status <= art_pkg::ST_OK;
            end
          endcase
          state <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            status     <= res_status;
            found      <= res_found;
            route_port <= res_port;
            route_hops <= res_hops;
            route_mac  <= res_mac;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
